@@ rtl/waypoint_travel_controller_defines.svh @@
// Assertion macros for the waypoint travel controller
`ifndef WAYPOINT_TRAVEL_CONTROLLER_DEFINES_SVH
`define WAYPOINT_TRAVEL_CONTROLLER_DEFINES_SVH

// Check that an antecedent implies a consequent on the next clock edge
`define WTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the same clock edge
`define WTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/wtc_pkg.sv @@
// Shared types and constants for the waypoint travel controller
package wtc_pkg;

    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_POS  = 2'd1;
    localparam logic [1:0] CMD_DEST = 2'd2;

    localparam logic [2:0] MOTOR_STOP  = 3'd0;
    localparam logic [2:0] MOTOR_FWD   = 3'd1;
    localparam logic [2:0] MOTOR_BACK  = 3'd2;
    localparam logic [2:0] MOTOR_UP    = 3'd3;
    localparam logic [2:0] MOTOR_DOWN  = 3'd4;

    localparam logic [1:0] STEER_NONE    = 2'd0;
    localparam logic [1:0] STEER_DISABLE = 2'd1;
    localparam logic [1:0] STEER_ENABLE  = 2'd2;

    localparam logic [15:0] PULSE_RESET = 16'd100;
    localparam logic [15:0] ANGLE_MAX   = 16'd46080;

    // Angles in degrees scaled by 2^16; 360 degrees needs 25 bits, signed work uses 27
    localparam int ANG_W = 27;
    localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;
    localparam int TABLE_LEN = 24;

    // Update classification from the datapath
    typedef struct packed {
        logic at_target;
        logic stuck;
        logic y_below;
        logic y_above;
        logic cordic_done;
    } wtc_status_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load_target;
        logic load_pos;
        logic cordic_start;
        logic cordic_second;
        logic commit_prev;
    } wtc_cmd_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 27'd2949120;
                5'd1:  v = 27'd1740967;
                5'd2:  v = 27'd919879;
                5'd3:  v = 27'd466945;
                5'd4:  v = 27'd234379;
                5'd5:  v = 27'd117304;
                5'd6:  v = 27'd58666;
                5'd7:  v = 27'd29335;
                5'd8:  v = 27'd14668;
                5'd9:  v = 27'd7334;
                5'd10: v = 27'd3667;
                5'd11: v = 27'd1833;
                5'd12: v = 27'd917;
                5'd13: v = 27'd458;
                5'd14: v = 27'd229;
                5'd15: v = 27'd115;
                5'd16: v = 27'd57;
                5'd17: v = 27'd29;
                5'd18: v = 27'd14;
                5'd19: v = 27'd7;
                5'd20: v = 27'd4;
                5'd21: v = 27'd2;
                5'd22: v = 27'd1;
                default: v = 27'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/wtc_cordic.sv @@
// Iterative CORDIC vectoring unit: direction of a vector in degrees * 2^16
module wtc_cordic #(
    parameter int VEC_WIDTH  = 26,
    parameter int ITERATIONS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [VEC_WIDTH-1:0]            vec_x,
    input  logic signed [VEC_WIDTH-1:0]            vec_y,
    output logic                                   done,
    output logic        [wtc_pkg::ANG_W-1:0]       angle
);

    // Growth of up to 1.65 plus sign flip: two spare bits
    localparam int XW = VEC_WIDTH + 2;
    localparam int CW = $clog2(ITERATIONS + 1);

    logic signed [XW-1:0]             x_reg, x_next;
    logic signed [XW-1:0]             y_reg, y_next;
    logic signed [wtc_pkg::ANG_W-1:0] z_reg, z_next;
    logic [CW-1:0]                    iter_reg, iter_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic signed [XW-1:0]             xs, ys, x_ext, y_ext;
    logic signed [wtc_pkg::ANG_W-1:0] step_ang;
    logic signed [wtc_pkg::ANG_W-1:0] z_wrap;

    assign x_ext = XW'(vec_x);
    assign y_ext = XW'(vec_y);
    assign xs = y_reg >>> iter_reg;
    assign ys = x_reg >>> iter_reg;
    assign step_ang = $signed(wtc_pkg::atan_entry(5'(iter_reg)));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // Pre-rotate into the right half plane
            if (vec_x < 0)
            begin
                x_next = -x_ext;
                y_next = -y_ext;
                z_next = wtc_pkg::DEG180;
            end
            else
            begin
                x_next = x_ext;
                y_next = y_ext;
                z_next = '0;
            end
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + xs;
                y_next = y_reg - ys;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - xs;
                y_next = y_reg + ys;
                z_next = z_reg - step_ang;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == CW'(ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Wrap into [0, 360): range stays within (-100, 280)
    assign z_wrap = (z_reg < 0) ? z_reg + wtc_pkg::DEG360 : z_reg;
    assign angle  = z_wrap;
    assign done   = done_reg;

endmodule

@@ rtl/wtc_datapath.sv @@
// Datapath: position state, classification and heading computation
module wtc_datapath #(
    parameter int POS_WIDTH  = 24,
    parameter int ITERATIONS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wtc_pkg::wtc_cmd_t           ctl,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] pos_z,
    output wtc_pkg::wtc_status_t        status,
    output logic [15:0]                 steer_angle
);

    localparam int VW = POS_WIDTH + 1;
    localparam int AW = wtc_pkg::ANG_W;

    logic signed [POS_WIDTH-1:0] prev_x_reg, prev_z_reg;
    logic signed [POS_WIDTH-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic signed [POS_WIDTH-1:0] cur_x_reg, cur_z_reg;
    logic signed [VW-1:0]        vec_x, vec_y;
    logic                        cdone;
    logic [AW-1:0]               cangle;
    logic signed [AW-1:0]        dir_a_reg;
    logic signed [AW-1:0]        diff, fold;
    logic [AW-1:0]               rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_z_reg <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            tgt_z_reg  <= '0;
        end
        else
        begin
            if (ctl.load_target)
            begin
                tgt_x_reg <= pos_x;
                tgt_y_reg <= pos_y;
                tgt_z_reg <= pos_z;
            end
            if (ctl.commit_prev)
            begin
                prev_x_reg <= pos_x;
                prev_z_reg <= pos_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_pos)
        begin
            cur_x_reg <= pos_x;
            cur_z_reg <= pos_z;
        end
        if (cdone)
        begin
            dir_a_reg <= $signed(cangle);
        end
    end

    // Classification works on the live input at acceptance
    assign status.at_target   = (pos_x == tgt_x_reg) && (pos_z == tgt_z_reg);
    assign status.stuck       = (pos_x == prev_x_reg) && (pos_z == prev_z_reg);
    assign status.y_below     = pos_y < tgt_y_reg;
    assign status.y_above     = pos_y > tgt_y_reg;
    assign status.cordic_done = cdone;

    // First pass: previous-move vector; second pass: to-target vector
    always_comb
    begin
        if (ctl.cordic_second)
        begin
            vec_x = VW'(tgt_x_reg) - VW'(cur_x_reg);
            vec_y = VW'(tgt_z_reg) - VW'(cur_z_reg);
        end
        else
        begin
            vec_x = VW'(pos_x) - VW'(prev_x_reg);
            vec_y = VW'(pos_z) - VW'(prev_z_reg);
        end
    end

    wtc_cordic #(
        .VEC_WIDTH  (VW),
        .ITERATIONS (ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.cordic_start),
        .vec_x  (vec_x),
        .vec_y  (vec_y),
        .done   (cdone),
        .angle  (cangle)
    );

    // Valid in the cycle the second pass finishes
    assign diff = dir_a_reg - $signed(cangle);
    always_comb
    begin
        fold = (diff < 0) ? diff + wtc_pkg::DEG360 : diff;
        if (fold > wtc_pkg::DEG180)
        begin
            fold = wtc_pkg::DEG360 - fold;
        end
    end
    assign rnd = (AW'(fold) + AW'(128)) >> 8;
    assign steer_angle = (rnd > AW'(wtc_pkg::ANGLE_MAX)) ? wtc_pkg::ANGLE_MAX : rnd[15:0];

endmodule

@@ rtl/wtc_controller.sv @@
// Controller: sequences commands and drives the result register
module wtc_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           in_cmd,
    input  wtc_pkg::wtc_status_t status,
    input  logic [15:0]          angle,
    input  logic [15:0]          pulse_ticks,
    output wtc_pkg::wtc_cmd_t    ctl,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [38:0]          m_tdata,
    output logic                 m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIR_A,
        ST_DIR_B,
        ST_OUT1,
        ST_OUT2
    } state_t;

    state_t      state_reg, state_next;
    logic        valid_reg, valid_next;
    logic [38:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic        accept;
    logic        out_free;

    // tdata fields from the lowest bit: motor_valid, motor_cmd, steer_change,
    // angle_valid, steer_angle, hold_ticks
    function automatic logic [38:0] pack(input logic mv, input logic [2:0] mc,
                                         input logic [1:0] sc, input logic av,
                                         input logic [15:0] ang, input logic [15:0] hold);
        begin
            return {hold, ang, av, sc, mc, mv};
        end
    endfunction

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctl.load_target   = accept && (in_cmd == wtc_pkg::CMD_DEST);
        ctl.load_pos      = accept && (in_cmd == wtc_pkg::CMD_POS);
        ctl.commit_prev   = accept && (in_cmd == wtc_pkg::CMD_POS);
        ctl.cordic_start  = (accept && (in_cmd == wtc_pkg::CMD_POS)
                             && !status.at_target && !status.stuck)
                            || ((state_reg == ST_DIR_A) && status.cordic_done);
        ctl.cordic_second = (state_reg == ST_DIR_A);
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        wtc_pkg::CMD_STOP:
                        begin
                            valid_next = 1'b1;
                            data_next  = pack(1'b1, wtc_pkg::MOTOR_STOP,
                                              wtc_pkg::STEER_DISABLE, 1'b0, '0, '0);
                            last_next  = 1'b1;
                        end
                        wtc_pkg::CMD_DEST:
                        begin
                            valid_next = 1'b1;
                            data_next  = pack(1'b1, wtc_pkg::MOTOR_FWD,
                                              wtc_pkg::STEER_NONE, 1'b0, '0, pulse_ticks);
                            last_next  = 1'b0;
                            state_next = ST_OUT2;
                        end
                        wtc_pkg::CMD_POS:
                        begin
                            priority if (status.at_target)
                            begin
                                valid_next = 1'b1;
                                data_next  = pack(1'b1,
                                    status.y_below ? wtc_pkg::MOTOR_UP :
                                    status.y_above ? wtc_pkg::MOTOR_DOWN :
                                    wtc_pkg::MOTOR_STOP,
                                    wtc_pkg::STEER_DISABLE, 1'b0, '0, '0);
                                last_next  = 1'b1;
                            end
                            else if (status.stuck)
                            begin
                                valid_next = 1'b1;
                                data_next  = pack(1'b1, wtc_pkg::MOTOR_BACK,
                                                  wtc_pkg::STEER_DISABLE, 1'b0, '0,
                                                  pulse_ticks);
                                last_next  = 1'b0;
                                state_next = ST_OUT2;
                            end
                            else
                            begin
                                state_next = ST_DIR_A;
                            end
                        end
                        default:
                        begin
                            // Unknown command: drop
                        end
                    endcase
                end
            end
            ST_DIR_A:
            begin
                if (status.cordic_done)
                begin
                    state_next = ST_DIR_B;
                end
            end
            ST_DIR_B:
            begin
                if (status.cordic_done)
                begin
                    state_next = ST_OUT1;
                    data_next  = pack(1'b0, wtc_pkg::MOTOR_STOP, wtc_pkg::STEER_ENABLE,
                                      1'b1, angle, '0);
                end
            end
            ST_OUT1:
            begin
                // Hold the angle item until the output register frees
                if (out_free)
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT2:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    data_next  = pack(1'b1, wtc_pkg::MOTOR_STOP, wtc_pkg::STEER_ENABLE,
                                      1'b0, '0, '0);
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            data_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            data_reg  <= data_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/waypoint_travel_controller.sv @@
// Top level of the waypoint travel controller
// Stop, arrive, stuck and destination items give their first result in the cycle after
// acceptance; a steering item runs two CORDIC passes before its angle item is registered.
// A new item is taken only when the controller is idle and the output is free; steering
// items take two passes of the shared iterative CORDIC; two-result items give two beats.
// Reset: rst_n clears the previous position and the target, sets pulse_ticks to 100.
`include "waypoint_travel_controller_defines.svh"

module waypoint_travel_controller #(
    parameter int POS_WIDTH        = 24,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cmd, pos_x, pos_y, pos_z from bit 0, zero-filled to whole bytes
    input  logic [((2+3*POS_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // motor_valid, motor_cmd, steer_change, angle_valid, steer_angle, hold_ticks
    output logic [39:0]            m_tdata,
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [1:0] REG_PULSE = 2'd0;

    logic [15:0]                 pulse_reg;
    logic [1:0]                  in_cmd;
    logic signed [POS_WIDTH-1:0] in_x, in_y, in_z;
    wtc_pkg::wtc_status_t        status;
    wtc_pkg::wtc_cmd_t           ctl;
    logic [15:0]                 angle;
    logic [38:0]                 out_data;

    assign in_cmd = s_tdata[1:0];
    assign in_x   = s_tdata[2 +: POS_WIDTH];
    assign in_y   = s_tdata[2+POS_WIDTH +: POS_WIDTH];
    assign in_z   = s_tdata[2+2*POS_WIDTH +: POS_WIDTH];

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= wtc_pkg::PULSE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_PULSE))
        begin
            pulse_reg <= pwdata[15:0];
        end
    end
    assign prdata = (paddr == REG_PULSE) ? {16'd0, pulse_reg} : 32'd0;

    wtc_datapath #(
        .POS_WIDTH  (POS_WIDTH),
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .pos_x       (in_x),
        .pos_y       (in_y),
        .pos_z       (in_z),
        .status      (status),
        .steer_angle (angle)
    );

    wtc_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_cmd      (in_cmd),
        .status      (status),
        .angle       (angle),
        .pulse_ticks (pulse_reg),
        .ctl         (ctl),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (out_data),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = {1'b0, out_data};

    `WTC_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata[22:7] <= wtc_pkg::ANGLE_MAX, "angle above 180 degrees")
    `WTC_ASSERT_NOW(a_no_accept_busy, m_tvalid && !m_tready, !s_tready, "accept while output stalled")
    `WTC_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost under stall")

endmodule
